// ----- hdl/stt_pkg.sv -----
// Package for the script text tokenizer.
// Holds result and bundle types, character codes and the queue depth default.
// No dependencies.
`timescale 1ns / 1ps

package stt_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_LBRACE = 8'h7B;
  localparam logic [7:0] CHAR_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tbyte;
    logic       quoted;
  } result_t;

  // Up to four results caused by one input item; last_idx is the count minus one.
  typedef struct packed {
    result_t [3:0] res;
    logic [1:0]    last_idx;
  } bundle_t;

endpackage

// ----- hdl/stt_front.sv -----
// Front end of the tokenizer: accepts text bytes, tracks the scan mode and
// builds the bundle of results that each byte causes. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      text_byte_i,
  output logic            push_o,
  output stt_pkg::bundle_t bundle_o
);

  typedef enum logic [4:0] {
    MODE_BETWEEN = 5'b00001,
    MODE_SLASH   = 5'b00010,
    MODE_COMMENT = 5'b00100,
    MODE_QUOTED  = 5'b01000,
    MODE_WORD    = 5'b10000
  } mode_e;

  mode_e mode_q, mode_d;
  stt_pkg::result_t [3:0] res;
  logic [2:0] n;
  logic do_word, do_start, is_white, is_single;

  function automatic stt_pkg::result_t mk(stt_pkg::kind_e kind, logic [7:0] tbyte, logic quoted);
    stt_pkg::result_t r;
    r.kind   = kind;
    r.tbyte  = tbyte;
    r.quoted = quoted;
    return r;
  endfunction

  assign is_white  = (text_byte_i <= stt_pkg::CHAR_SPACE) || text_byte_i[7];
  assign is_single = (text_byte_i == stt_pkg::CHAR_LBRACE) || (text_byte_i == stt_pkg::CHAR_RBRACE)
                  || (text_byte_i == stt_pkg::CHAR_LPAREN) || (text_byte_i == stt_pkg::CHAR_RPAREN)
                  || (text_byte_i == stt_pkg::CHAR_SQUOTE) || (text_byte_i == stt_pkg::CHAR_COMMA);

  always_comb begin
    res      = '0;
    n        = 3'd0;
    mode_d   = mode_q;
    do_word  = 1'b0;
    do_start = 1'b0;
    unique case (mode_q)
      MODE_SLASH: begin
        if (text_byte_i == stt_pkg::CHAR_SLASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          res[0]  = mk(stt_pkg::KIND_BYTE, stt_pkg::CHAR_SLASH, 1'b0);
          n       = 3'd1;
          do_word = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (text_byte_i == stt_pkg::CHAR_NUL) begin
          res[0] = mk(stt_pkg::KIND_EOT, 8'h00, 1'b0);
          n      = 3'd1;
          mode_d = MODE_BETWEEN;
        end else if (text_byte_i == stt_pkg::CHAR_NL) begin
          mode_d = MODE_BETWEEN;
        end
      end
      MODE_QUOTED: begin
        if (text_byte_i == stt_pkg::CHAR_DQUOTE) begin
          res[0] = mk(stt_pkg::KIND_END, 8'h00, 1'b1);
          n      = 3'd1;
          mode_d = MODE_BETWEEN;
        end else if (text_byte_i == stt_pkg::CHAR_NUL) begin
          res[0] = mk(stt_pkg::KIND_END, 8'h00, 1'b1);
          res[1] = mk(stt_pkg::KIND_EOT, 8'h00, 1'b0);
          n      = 3'd2;
          mode_d = MODE_BETWEEN;
        end else begin
          res[0] = mk(stt_pkg::KIND_BYTE, text_byte_i, 1'b1);
          n      = 3'd1;
        end
      end
      MODE_WORD: begin
        do_word = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_word) begin
      if (is_white || is_single) begin
        res[n[1:0]] = mk(stt_pkg::KIND_END, 8'h00, 1'b0);
        n           = n + 3'd1;
        mode_d      = MODE_BETWEEN;
        if ((text_byte_i == stt_pkg::CHAR_NUL) || is_single) begin
          do_start = 1'b1;
        end
      end else begin
        res[n[1:0]] = mk(stt_pkg::KIND_BYTE, text_byte_i, 1'b0);
        n           = n + 3'd1;
        mode_d      = MODE_WORD;
      end
    end

    if (do_start) begin
      priority if (text_byte_i == stt_pkg::CHAR_NUL) begin
        res[n[1:0]] = mk(stt_pkg::KIND_EOT, 8'h00, 1'b0);
        n           = n + 3'd1;
        mode_d      = MODE_BETWEEN;
      end else if (is_white) begin
        mode_d = MODE_BETWEEN;
      end else if (text_byte_i == stt_pkg::CHAR_SLASH) begin
        mode_d = MODE_SLASH;
      end else if (text_byte_i == stt_pkg::CHAR_DQUOTE) begin
        mode_d = MODE_QUOTED;
      end else if (is_single) begin
        res[n[1:0]] = mk(stt_pkg::KIND_BYTE, text_byte_i, 1'b0);
        n           = n + 3'd1;
        res[n[1:0]] = mk(stt_pkg::KIND_END, 8'h00, 1'b0);
        n           = n + 3'd1;
        mode_d      = MODE_BETWEEN;
      end else begin
        res[n[1:0]] = mk(stt_pkg::KIND_BYTE, text_byte_i, 1'b0);
        n           = n + 3'd1;
        mode_d      = MODE_WORD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BETWEEN;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

  assign push_o            = accept_i && (n != 3'd0);
  assign bundle_o.res      = res;
  assign bundle_o.last_idx = 2'(n - 3'd1);

endmodule

// ----- hdl/stt_queue.sv -----
// Bundle queue between the tokenizer front end and the result serializer.
// A small circular buffer of result bundles. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_queue #(
  parameter int unsigned Depth = stt_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  stt_pkg::bundle_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             avail_o,
  output stt_pkg::bundle_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  stt_pkg::bundle_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [AW:0]   cnt_q;

  function automatic logic [AW-1:0] incr(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= incr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= incr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AW+1)'(1);
      end
    end
  end

endmodule

// ----- hdl/stt_back.sv -----
// Back end of the tokenizer: walks the head bundle into the output register,
// one result per cycle unless stalled, popping it after the last. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  stt_pkg::bundle_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       token_byte_o,
  output logic             quoted_o,
  output logic             last_o
);

  logic [1:0]       idx_q;
  logic             valid_q;
  stt_pkg::result_t res_q;
  logic             last_q;
  logic             load, at_last;

  assign load    = avail_i && (!valid_q || !out_stall_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= head_i.res[idx_q];
      last_q <= at_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign kind_o       = res_q.kind;
  assign token_byte_o = res_q.tbyte;
  assign quoted_o     = res_q.quoted;
  assign last_o       = last_q;

endmodule

// ----- hdl/script_text_tokenizer.sv -----
// Top level of the script text tokenizer.
// Instantiates stt_front, stt_queue and stt_back; uses stt_pkg.
//
// Usage: text bytes enter on the input channel (in_valid_i, in_stall_o,
// text_byte_i), one item per byte, and a zero byte ends the text. Results
// leave on the output channel (out_valid_o, out_stall_i) as kind_o,
// token_byte_o, quoted_o and last_o; last_o marks the final result that one
// input byte causes. A byte may cause no result at all.
// Throughput: one input byte per cycle while the queue is not full, and one
// result per cycle on the output while it is not stalled. A byte that causes
// several results occupies the output for each of them in turn; the bundle
// queue of QueueDepth entries absorbs these bursts, and the input stalls only
// when that queue is full. The first result of a byte passes through the
// bundle queue and then the output register before it is valid on the output.
// Reset puts the scanner between tokens and empties the queue and the output
// register. A stalled output holds its result; the input keeps flowing until
// the queue fills.
`timescale 1ns / 1ps

module script_text_tokenizer #(
  parameter int unsigned QueueDepth = stt_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] token_byte_o,
  output logic       quoted_o,
  output logic       last_o
);

  logic             full, avail, push, pop, accept;
  stt_pkg::bundle_t push_data, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  stt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  stt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .avail_o     (avail),
    .head_o      (head)
  );

  stt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (avail),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .token_byte_o (token_byte_o),
    .quoted_o     (quoted_o),
    .last_o       (last_o)
  );

endmodule

// ----- hdl/stt_checker.sv -----
// Port-level checks for the script text tokenizer, bound to the top level.
// Uses stt_pkg.
`timescale 1ns / 1ps

module stt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] token_byte_o,
  input logic       quoted_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output item dropped while stalled.");

  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == stt_pkg::KIND_EOT) |-> last_o && !quoted_o)
    else $error("End of text is not the final unquoted result of its byte.");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != stt_pkg::KIND_BYTE) |-> (token_byte_o == stt_pkg::CHAR_NUL))
    else $error("Token byte is not zero on a mark result.");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == stt_pkg::KIND_BYTE) || (kind_o == stt_pkg::KIND_END)
                    || (kind_o == stt_pkg::KIND_EOT))
    else $error("Result kind carries an unused code.");

endmodule

bind script_text_tokenizer stt_checker u_stt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .token_byte_o (token_byte_o),
  .quoted_o     (quoted_o),
  .last_o       (last_o)
);

// ----- sim/script_text_tokenizer_tb.sv -----
// Self-checking testbench for script_text_tokenizer: directed and random script text,
// with random idle and stall cycles on both sides, checked by a scoreboard class.
// Depends on stt_pkg and the script_text_tokenizer RTL.
`timescale 1ns / 1ps

module script_text_tokenizer_tb;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned TEXT_BYTES   = 410;

  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_DEL  = 8'h7F;
  localparam logic [7:0] HIGH_LOW  = 8'h80;
  localparam logic [7:0] HIGH_TOP  = 8'hFF;

  typedef enum logic [2:0] {
    SCAN_BETWEEN = 3'd0,
    SCAN_SLASH   = 3'd1,
    SCAN_COMMENT = 3'd2,
    SCAN_QUOTED  = 3'd3,
    SCAN_WORD    = 3'd4
  } scan_e;

  typedef struct packed {
    stt_pkg::result_t res;
    logic             last;
  } token_out_t;

  class token_scoreboard;
    scan_e        mode;
    token_out_t   burst[$];
    token_out_t   pending[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  tokens_closed;
    int unsigned  texts_closed;

    function new();
      mode = SCAN_BETWEEN;
      mismatches = 0;
      results_checked = 0;
      tokens_closed = 0;
      texts_closed = 0;
    endfunction

    function bit is_single(logic [7:0] b);
      return b == stt_pkg::CHAR_LBRACE || b == stt_pkg::CHAR_RBRACE ||
             b == stt_pkg::CHAR_LPAREN || b == stt_pkg::CHAR_RPAREN ||
             b == stt_pkg::CHAR_SQUOTE || b == stt_pkg::CHAR_COMMA;
    endfunction

    // Bytes above 0x7F count as whitespace, as with a signed char.
    function bit is_white(logic [7:0] b);
      return b <= stt_pkg::CHAR_SPACE || b[7];
    endfunction

    function void add(stt_pkg::kind_e k, logic [7:0] b, logic q);
      token_out_t t;
      t.res.kind = k;
      t.res.tbyte = b;
      t.res.quoted = q;
      t.last = 1'b0;
      burst.push_back(t);
    endfunction

    function void start_token(logic [7:0] b);
      if (b == stt_pkg::CHAR_NUL) begin
        add(stt_pkg::KIND_EOT, stt_pkg::CHAR_NUL, 1'b0);
        mode = SCAN_BETWEEN;
      end else if (is_white(b)) begin
        mode = SCAN_BETWEEN;
      end else if (b == stt_pkg::CHAR_SLASH) begin
        mode = SCAN_SLASH;
      end else if (b == stt_pkg::CHAR_DQUOTE) begin
        mode = SCAN_QUOTED;
      end else if (is_single(b)) begin
        add(stt_pkg::KIND_BYTE, b, 1'b0);
        add(stt_pkg::KIND_END, stt_pkg::CHAR_NUL, 1'b0);
        mode = SCAN_BETWEEN;
      end else begin
        add(stt_pkg::KIND_BYTE, b, 1'b0);
        mode = SCAN_WORD;
      end
    endfunction

    function void word_next(logic [7:0] b);
      if (is_white(b) || is_single(b)) begin
        add(stt_pkg::KIND_END, stt_pkg::CHAR_NUL, 1'b0);
        mode = SCAN_BETWEEN;
        if (b == stt_pkg::CHAR_NUL || is_single(b)) start_token(b);
      end else begin
        add(stt_pkg::KIND_BYTE, b, 1'b0);
        mode = SCAN_WORD;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      token_out_t t;
      burst.delete();
      case (mode)
        SCAN_SLASH: begin
          if (b == stt_pkg::CHAR_SLASH) begin
            mode = SCAN_COMMENT;
          end else begin
            add(stt_pkg::KIND_BYTE, stt_pkg::CHAR_SLASH, 1'b0);
            word_next(b);
          end
        end
        SCAN_COMMENT: begin
          if (b == stt_pkg::CHAR_NUL) begin
            add(stt_pkg::KIND_EOT, stt_pkg::CHAR_NUL, 1'b0);
            mode = SCAN_BETWEEN;
          end else if (b == stt_pkg::CHAR_NL) begin
            mode = SCAN_BETWEEN;
          end
        end
        SCAN_QUOTED: begin
          if (b == stt_pkg::CHAR_DQUOTE) begin
            add(stt_pkg::KIND_END, stt_pkg::CHAR_NUL, 1'b1);
            mode = SCAN_BETWEEN;
          end else if (b == stt_pkg::CHAR_NUL) begin
            add(stt_pkg::KIND_END, stt_pkg::CHAR_NUL, 1'b1);
            add(stt_pkg::KIND_EOT, stt_pkg::CHAR_NUL, 1'b0);
            mode = SCAN_BETWEEN;
          end else begin
            add(stt_pkg::KIND_BYTE, b, 1'b1);
          end
        end
        SCAN_WORD: word_next(b);
        default: start_token(b);
      endcase
      if (burst.size() > 0) begin
        t = burst.pop_back();
        t.last = 1'b1;
        burst.push_back(t);
      end
      foreach (burst[i]) pending.push_back(burst[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] tbyte, logic quoted,
                               logic last);
      token_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d byte %02h",
                 $time, kind, tbyte, " quoted %0b last %0b", quoted, last);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      results_checked++;
      if (kind != want.res.kind) begin
        $display("%0t: kind: expected %0d, actual %0d", $time, want.res.kind, kind);
        mismatches++;
      end
      if (tbyte != want.res.tbyte) begin
        $display("%0t: token_byte: expected %02h, actual %02h", $time, want.res.tbyte, tbyte);
        mismatches++;
      end
      if (quoted != want.res.quoted) begin
        $display("%0t: quoted: expected %0b, actual %0b", $time, want.res.quoted, quoted);
        mismatches++;
      end
      if (last != want.last) begin
        $display("%0t: last: expected %0b, actual %0b", $time, want.last, last);
        mismatches++;
      end
      if (want.res.kind == stt_pkg::KIND_END) tokens_closed++;
      if (want.res.kind == stt_pkg::KIND_EOT) texts_closed++;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] text_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] token_byte_o;
  logic       quoted_o;
  logic       last_o;

  token_scoreboard sb;
  bit              gaps_on;
  int unsigned     bytes_sent;
  int unsigned     stall_left;
  int unsigned     quiet_cycles;

  script_text_tokenizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .token_byte_o (token_byte_o),
    .quoted_o     (quoted_o),
    .last_o       (last_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char(input bit at_start);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(stt_pkg::CHAR_SPACE + 1, CHAR_DEL));
    end while (sb.is_single(c) ||
               (at_start && (c == stt_pkg::CHAR_SLASH || c == stt_pkg::CHAR_DQUOTE)));
    return c;
  endfunction

  function automatic logic [7:0] white_char();
    case ($urandom_range(0, 4))
      0: return stt_pkg::CHAR_SPACE;
      1: return stt_pkg::CHAR_NL;
      2: return CHAR_TAB;
      3: return 8'($urandom_range(1, stt_pkg::CHAR_SPACE - 1));
      default: return 8'($urandom_range(HIGH_LOW, HIGH_TOP));
    endcase
  endfunction

  function automatic logic [7:0] single_char();
    case ($urandom_range(0, 5))
      0: return stt_pkg::CHAR_LBRACE;
      1: return stt_pkg::CHAR_RBRACE;
      2: return stt_pkg::CHAR_LPAREN;
      3: return stt_pkg::CHAR_RPAREN;
      4: return stt_pkg::CHAR_SQUOTE;
      default: return stt_pkg::CHAR_COMMA;
    endcase
  endfunction

  // Mostly well-formed tokens with random content, plus noise and broken pieces.
  task automatic send_fragment();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    len = $urandom_range(0, 6);
    if (pick < 28) begin
      send_byte(word_char(1'b1));
      repeat (len) send_byte(word_char(1'b0));
    end else if (pick < 42) begin
      send_byte(stt_pkg::CHAR_DQUOTE);
      repeat (len) begin
        do c = 8'($urandom_range(1, HIGH_TOP)); while (c == stt_pkg::CHAR_DQUOTE);
        send_byte(c);
      end
      if ($urandom_range(0, 9) != 0) send_byte(stt_pkg::CHAR_DQUOTE);
    end else if (pick < 56) begin
      send_byte(single_char());
    end else if (pick < 70) begin
      repeat (len + 1) send_byte(white_char());
    end else if (pick < 78) begin
      send_byte(stt_pkg::CHAR_SLASH);
      send_byte(stt_pkg::CHAR_SLASH);
      repeat (len) begin
        do c = 8'($urandom_range(1, HIGH_TOP)); while (c == stt_pkg::CHAR_NL);
        send_byte(c);
      end
      send_byte(stt_pkg::CHAR_NL);
    end else if (pick < 84) begin
      send_byte(stt_pkg::CHAR_SLASH);
      repeat (len) send_byte(word_char(1'b0));
    end else if (pick < 88) begin
      send_byte(stt_pkg::CHAR_NUL);
    end else begin
      repeat (len + 1) send_byte(8'($urandom_range(0, HIGH_TOP)));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(kind_o, token_byte_o, quoted_o, last_o);
        stall_left = gaps_on ? $urandom_range(0, 17) : 0;
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("%0t: no item moved on either side for %0d cycles", $time, QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    text_byte_i = stt_pkg::CHAR_NUL;
    gaps_on = 1'b0;
    bytes_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on = 1'($urandom_range(0, 1));

    send_text("ab\"c)");
    send_text("\"\"");
    send_text("/(");
    send_text("//,\n");
    send_byte(stt_pkg::CHAR_LBRACE);
    send_byte(CHAR_DEL);
    send_byte(stt_pkg::CHAR_RBRACE);
    send_byte(HIGH_TOP);
    send_byte(HIGH_LOW);
    send_text("\"'");
    send_byte(stt_pkg::CHAR_NUL);
    send_text("w");
    send_byte(stt_pkg::CHAR_NUL);
    send_byte(stt_pkg::CHAR_SLASH);
    send_byte(stt_pkg::CHAR_NUL);

    while (bytes_sent < TEXT_BYTES) begin
      if ($urandom_range(0, 7) == 0) gaps_on = !gaps_on;
      send_fragment();
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Fed %0d text bytes with random gaps and stalls; checked %0d results,",
             bytes_sent, sb.results_checked);
    $display("among them %0d token ends and %0d text ends.", sb.tokens_closed, sb.texts_closed);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/script_text_tokenizer.sv
hdl/stt_checker.sv
sim/script_text_tokenizer_tb.sv
